/* rtl/windowed_pid_heater_control_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the windowed PID heater controller
// Clocked, reset-qualified property wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_PID_HEATER_CONTROL_TOP_MACROS_SVH
`define WINDOWED_PID_HEATER_CONTROL_TOP_MACROS_SVH

// condition holds at every edge outside reset
`define WPHC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define WPHC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/wphc_pkg.sv */
// ----------------------------------------------------------------------------
// wphc_pkg
// Widths, register indexes and word layouts of the windowed PID heater
// controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wphc_pkg;

   localparam int TEMP_W      = 14;
   localparam int TARGET_W    = 13;
   localparam int GAIN_W      = 16;
   localparam int BIAS_W      = 9;
   localparam int ERR_W       = 15;
   localparam int DRIVE_W     = 8;
   localparam int FRAC_SHIFT  = 12;
   localparam int DERIV_TAP   = 4;
   localparam int SETTLE_MUL  = 20;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic signed [TEMP_W-1:0] MAX_TEMP_RESET = 14'sd4800;
   localparam logic [DRIVE_W-1:0]       DRIVE_MAX      = 8'd255;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_TEMP = 3'd0,
      CSR_PROP_GAIN   = 3'd1,
      CSR_INTEG_GAIN  = 3'd2,
      CSR_DERIV_GAIN  = 3'd3,
      CSR_BIAS        = 3'd4,
      CSR_MIN_TEMP    = 3'd5,
      CSR_MAX_TEMP    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [RSP_TDATA_W-DRIVE_W-3:0] pad;
      logic                           settled;
      logic                           fault;
      logic [DRIVE_W-1:0]             drive;
   } rsp_word_type;

endpackage

/* rtl/windowed_pid_heater_control_top.sv */
// ----------------------------------------------------------------------------
// windowed_pid_heater_control_top
// Windowed PID heater controller: range check, error history with running
// sum, three gain products, saturated drive and settled flag.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata: measured_temp; tuser: sample_tick
//  rsp     | out       | rsp_tvalid/tready    | tdata: drive, fault, settled
//  csr     | in        | csr_wen              | csr_index, csr_wdata
//
//  One word per cycle while rsp_tready is high; rsp_tvalid is registered.
//  The history and running sum update at accept of an in-range tick word; the
//  gain products and clamp then run from the stage into the result register.
//  A stalled result holds the stage behind it; req_tready drops only when both
//  the stage and the result register are full and rsp_tready is low.
//  Synchronous reset clears history, sum and valids and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "windowed_pid_heater_control_top_macros.svh"

module windowed_pid_heater_control_top #(
   parameter int WINDOW = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [wphc_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [13:0] measured_temp
   input  logic                                req_tuser,  // [0] sample_tick
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [wphc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // [7:0] drive, [8] fault, [9] settled
   input  logic                                csr_wen,
   input  logic [wphc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wphc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ERR_W  = wphc_pkg::ERR_W;
   localparam int SUM_W  = ERR_W + $clog2(WINDOW);
   localparam int GS_W   = wphc_pkg::GAIN_W + 1;
   localparam int PP_W   = ERR_W + GS_W;
   localparam int PI_W   = SUM_W + GS_W;
   localparam int DD_W   = ERR_W + 1;
   localparam int PD_W   = DD_W + GS_W;
   localparam int DS_W   = PI_W - wphc_pkg::FRAC_SHIFT + 2;
   localparam int CMP_W  = SUM_W + 6;

   // configuration
   logic [wphc_pkg::TARGET_W-1:0]      target_temp_ff, target_temp_in;
   logic [wphc_pkg::GAIN_W-1:0]        prop_gain_ff, prop_gain_in;
   logic [wphc_pkg::GAIN_W-1:0]        integ_gain_ff, integ_gain_in;
   logic [wphc_pkg::GAIN_W-1:0]        deriv_gain_ff, deriv_gain_in;
   logic signed [wphc_pkg::BIAS_W-1:0] bias_ff, bias_in;
   logic signed [wphc_pkg::TEMP_W-1:0] min_temp_ff, min_temp_in;
   logic signed [wphc_pkg::TEMP_W-1:0] max_temp_ff, max_temp_in;

   always_comb begin
      target_temp_in = target_temp_ff;
      prop_gain_in   = prop_gain_ff;
      integ_gain_in  = integ_gain_ff;
      deriv_gain_in  = deriv_gain_ff;
      bias_in        = bias_ff;
      min_temp_in    = min_temp_ff;
      max_temp_in    = max_temp_ff;
      if (csr_wen) begin
         case (wphc_pkg::csr_index_type'(csr_index))
            wphc_pkg::CSR_TARGET_TEMP: target_temp_in = csr_wdata[wphc_pkg::TARGET_W-1:0];
            wphc_pkg::CSR_PROP_GAIN:   prop_gain_in   = csr_wdata;
            wphc_pkg::CSR_INTEG_GAIN:  integ_gain_in  = csr_wdata;
            wphc_pkg::CSR_DERIV_GAIN:  deriv_gain_in  = csr_wdata;
            wphc_pkg::CSR_BIAS:        bias_in        = $signed(csr_wdata[wphc_pkg::BIAS_W-1:0]);
            wphc_pkg::CSR_MIN_TEMP:    min_temp_in    = $signed(csr_wdata[wphc_pkg::TEMP_W-1:0]);
            wphc_pkg::CSR_MAX_TEMP:    max_temp_in    = $signed(csr_wdata[wphc_pkg::TEMP_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_temp_ff <= '0;
         prop_gain_ff   <= '0;
         integ_gain_ff  <= '0;
         deriv_gain_ff  <= '0;
         bias_ff        <= '0;
         min_temp_ff    <= '0;
         max_temp_ff    <= wphc_pkg::MAX_TEMP_RESET;
      end else begin
         target_temp_ff <= target_temp_in;
         prop_gain_ff   <= prop_gain_in;
         integ_gain_ff  <= integ_gain_in;
         deriv_gain_ff  <= deriv_gain_in;
         bias_ff        <= bias_in;
         min_temp_ff    <= min_temp_in;
         max_temp_ff    <= max_temp_in;
      end
   end

   // handshake
   logic advance;
   logic req_accept;
   logic s1_valid_ff, s1_valid_in;
   logic s1_fault_ff, s1_fault_in;
   logic rsp_valid_ff, rsp_valid_in;
   wphc_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // history and running sum, updated at accept of an in-range tick word
   logic signed [wphc_pkg::TEMP_W-1:0] meas;
   logic                               out_of_range;
   logic signed [ERR_W-1:0]            err;
   logic signed [ERR_W-1:0]            hist_ff [WINDOW];
   logic signed [ERR_W-1:0]            hist_in [WINDOW];
   logic signed [SUM_W-1:0]            sum_ff, sum_in;

   assign meas         = $signed(req_tdata[wphc_pkg::TEMP_W-1:0]);
   assign out_of_range = (meas < min_temp_ff) || (meas > max_temp_ff);
   assign err          = $signed({2'b00, target_temp_ff}) - ERR_W'(meas);

   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         hist_in[i] = hist_ff[i];
      end
      sum_in      = sum_ff;
      s1_fault_in = s1_fault_ff;
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_fault_in = out_of_range;
         if (!out_of_range && req_tuser) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
               hist_in[i] = hist_ff[i+1];
            end
            hist_in[WINDOW-1] = err;
            sum_in = sum_ff - SUM_W'(hist_ff[0]) + SUM_W'(err);
         end
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            hist_ff[i] <= '0;
         end
         sum_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s1_fault_ff <= 1'b0;
      end else begin
         for (int i = 0; i < WINDOW; i++) begin
            hist_ff[i] <= hist_in[i];
         end
         sum_ff      <= sum_in;
         s1_valid_ff <= s1_valid_in;
         s1_fault_ff <= s1_fault_in;
      end
   end

   // gain products, clamp and settled test
   logic signed [PP_W-1:0]  p_prod;
   logic signed [PI_W-1:0]  i_prod;
   logic signed [DD_W-1:0]  d_diff;
   logic signed [PD_W-1:0]  d_prod;
   logic signed [DS_W-1:0]  drive_sum;
   logic [wphc_pkg::DRIVE_W-1:0] drive;
   logic signed [CMP_W-1:0] sum20;
   logic signed [CMP_W-1:0] wt;
   logic                    settled;

   assign p_prod = hist_ff[WINDOW-1] * $signed({1'b0, prop_gain_ff});
   assign i_prod = sum_ff * $signed({1'b0, integ_gain_ff});
   assign d_diff = DD_W'(hist_ff[0]) - DD_W'(hist_ff[wphc_pkg::DERIV_TAP]);
   assign d_prod = d_diff * $signed({1'b0, deriv_gain_ff});

   assign drive_sum = DS_W'(p_prod >>> wphc_pkg::FRAC_SHIFT)
                    + DS_W'(i_prod >>> wphc_pkg::FRAC_SHIFT)
                    + DS_W'(d_prod >>> wphc_pkg::FRAC_SHIFT)
                    + DS_W'(bias_ff);

   always_comb begin
      if (drive_sum < 0) begin
         drive = '0;
      end else if (drive_sum > DS_W'(wphc_pkg::DRIVE_MAX)) begin
         drive = wphc_pkg::DRIVE_MAX;
      end else begin
         drive = drive_sum[wphc_pkg::DRIVE_W-1:0];
      end
   end

   assign sum20   = CMP_W'(sum_ff) * CMP_W'(wphc_pkg::SETTLE_MUL);
   assign wt      = CMP_W'(WINDOW) * $signed(CMP_W'(target_temp_ff));
   assign settled = (sum20 > -wt) && (sum20 < wt);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (advance) begin
         rsp_valid_in         = s1_valid_ff;
         rsp_word_in.pad      = '0;
         rsp_word_in.fault    = s1_fault_ff;
         rsp_word_in.settled  = !s1_fault_ff && settled;
         rsp_word_in.drive    = s1_fault_ff ? '0 : drive;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;

   `WPHC_ASSERT_ALWAYS(a_fault_off,
      !(rsp_valid_ff && rsp_word_ff.fault) || (rsp_word_ff.drive == '0 && !rsp_word_ff.settled),
      "fault word carries nonzero drive or settled")
   `WPHC_ASSERT_NEXT(a_fault_keeps_sum, req_accept && out_of_range,
      sum_ff == $past(sum_ff) && hist_ff[WINDOW-1] == $past(hist_ff[WINDOW-1]),
      "out-of-range word changed the history")
   `WPHC_ASSERT_NEXT(a_tick_shifts, req_accept && !out_of_range && req_tuser,
      hist_ff[0] == $past(hist_ff[1]) && hist_ff[WINDOW-1] == $past(err),
      "history did not shift on tick")
   `WPHC_ASSERT_ALWAYS(a_settled_target,
      !(rsp_valid_ff && rsp_word_ff.settled) || target_temp_ff != '0,
      "settled reported with zero target")
   `WPHC_ASSERT_NEXT(a_stage_held, s1_valid_ff && !advance,
      s1_valid_ff && $stable(sum_ff),
      "stalled stage lost its word")

endmodule
